// ----- design/kcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// kcmp_pkg
// shared types and constants of the keyed cache with mark purge
// ----------------------------------------------------------------------------
`default_nettype none
package kcmp_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int CFG_W       = 9;
  localparam logic [CFG_W-1:0] MAX_RST   = 9'd256;
  localparam logic [CFG_W-1:0] FMARK_RST = 9'd192;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_MISS    = 2'd1,
    STS_REFUSED = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_MAX   = 1'b0,
    CFG_FMARK = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] tstamp;
    logic [31:0] order;
  } entry_t;

endpackage
`default_nettype wire

// ----- design/kcmp_store.sv -----
// ----------------------------------------------------------------------------
// kcmp_store
// entry memories: valid bits and payload, one write and one read port each
// ----------------------------------------------------------------------------
`default_nettype none
module kcmp_store #(
  parameter int ENTRIES = kcmp_pkg::ENTRIES_DEF,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  wire logic             clk,
  input  wire logic             v_we,
  input  wire logic [AW-1:0]    v_waddr,
  input  wire logic             v_wdata,
  input  wire logic             p_we,
  input  wire logic [AW-1:0]    p_waddr,
  input  wire kcmp_pkg::entry_t p_wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic                  v_rdata,
  output kcmp_pkg::entry_t      p_rdata
);

  logic             vmem [ENTRIES];
  kcmp_pkg::entry_t pmem [ENTRIES];

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_rdata <= vmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_rdata <= pmem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/keyed_cache_with_mark_purge_top.sv -----
// ----------------------------------------------------------------------------
// keyed_cache_with_mark_purge_top
// keyed entry store with fetch, insert and remove, purging by mark time
//
//  channel | ports                                  | dir
//  in      | in_valid in_stall in_op in_key ...     | transfer in
//  out     | out_valid out_stall out_hit ...        | transfer out
//  cfg     | cfg_we cfg_index cfg_data              | write only
//
//  an item holds the input side from its accept through the sweep over all
//  entries (with read latency and a drain step) and the finish state, which
//  waits while a result is still stalled; its result is registered as it
//  leaves finish; a nop op skips the sweep
//  after reset a clearing pass over all entries runs before any transfer
//  the next item is taken while a result still waits on out_stall
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_cache_with_mark_purge_top #(
  parameter int ENTRIES = kcmp_pkg::ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_data_in,
  input  wire logic [31:0] in_now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic [31:0]      out_data_out,
  output logic [1:0]       out_status,
  output logic [8:0]       out_entry_count,
  output logic [8:0]       out_purged_count,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > 9) ? CW : 9;

  kcmp_pkg::state_t state_r, state_nxt;
  logic [8:0]    max_r, fmark_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] purged_r, purged_nxt;
  logic [31:0]   serial_r, serial_nxt;
  logic [31:0]   mark_r, mark_nxt;
  logic [AW:0]   iss_r, iss_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;

  kcmp_pkg::op_t op_r;
  logic [31:0]   key_r, din_r, now_r;
  logic          do_purge_r, do_purge_nxt;

  logic          found_r, found_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]   best_age_r, best_age_nxt;
  logic [31:0]   best_val_r, best_val_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;

  logic             v_we, v_wdata, p_we, v_rdata;
  logic [AW-1:0]    v_waddr;
  kcmp_pkg::entry_t p_wdata, p_rdata;

  logic          out_valid_nxt, hit_nxt;
  logic [31:0]   dout_nxt;
  logic [1:0]    status_nxt;

  logic [31:0]   age;
  logic          slot_free, old_entry;
  logic [XW-1:0] cnt_left, cnt_inc;
  logic          full_acc, full_left;
  logic          in_xfer;

  kcmp_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
    .clk     (clk),
    .v_we    (v_we),
    .v_waddr (v_waddr),
    .v_wdata (v_wdata),
    .p_we    (p_we),
    .p_waddr (free_idx_r),
    .p_wdata (p_wdata),
    .raddr   (iss_r[AW-1:0]),
    .v_rdata (v_rdata),
    .p_rdata (p_rdata)
  );

  assign in_stall = (state_r != kcmp_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign full_acc  = (XW'(count_r) >= XW'(max_r)) || (XW'(count_r) >= XW'(ENTRIES));
  assign cnt_left  = XW'(count_r) - XW'(purged_r);
  assign cnt_inc   = cnt_left + XW'(1);
  assign full_left = (cnt_left >= XW'(max_r)) || (cnt_left >= XW'(ENTRIES));
  assign age       = serial_r - p_rdata.order;
  assign old_entry = do_purge_r && v_rdata && (p_rdata.tstamp < mark_r);
  assign slot_free = old_entry || !v_rdata;
  assign p_wdata   = '{key: key_r, value: din_r, tstamp: now_r, order: serial_r + 32'd1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= kcmp_pkg::MAX_RST;
      fmark_r <= kcmp_pkg::FMARK_RST;
    end else if (cfg_we) begin
      case (kcmp_pkg::cfg_idx_t'(cfg_index))
        kcmp_pkg::CFG_MAX:   max_r   <= cfg_data;
        kcmp_pkg::CFG_FMARK: fmark_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kcmp_pkg::ST_CLEAR;
      count_r   <= '0;
      serial_r  <= '0;
      mark_r    <= '0;
      iss_r     <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      serial_r  <= serial_nxt;
      mark_r    <= mark_nxt;
      iss_r     <= iss_nxt;
      pend_r    <= pend_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= kcmp_pkg::op_t'(in_op);
      key_r <= in_key;
      din_r <= in_data_in;
      now_r <= in_now;
    end
    do_purge_r <= do_purge_nxt;
    purged_r   <= purged_nxt;
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    best_val_r <= best_val_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    if (state_r == kcmp_pkg::ST_FINISH && state_nxt == kcmp_pkg::ST_IDLE) begin
      out_hit          <= hit_nxt;
      out_data_out     <= dout_nxt;
      out_status       <= status_nxt;
      out_entry_count  <= 9'(XW'(count_nxt));
      out_purged_count <= 9'(XW'(purged_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    serial_nxt    = serial_r;
    mark_nxt      = mark_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    do_purge_nxt  = do_purge_r;
    purged_nxt    = purged_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_age_nxt  = best_age_r;
    best_val_nxt  = best_val_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    out_valid_nxt = out_valid && out_stall;
    hit_nxt       = 1'b0;
    dout_nxt      = '0;
    status_nxt    = kcmp_pkg::STS_DONE;
    v_we          = 1'b0;
    v_waddr       = pend_idx_r;
    v_wdata       = 1'b0;
    p_we          = 1'b0;
    case (state_r)
      kcmp_pkg::ST_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = iss_r[AW-1:0];
        iss_nxt = iss_r + 1'b1;
        if (iss_r == (AW+1)'(ENTRIES - 1)) begin
          iss_nxt   = '0;
          state_nxt = kcmp_pkg::ST_IDLE;
        end
      end
      kcmp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          iss_nxt      = '0;
          pend_nxt     = 1'b0;
          purged_nxt   = '0;
          found_nxt    = 1'b0;
          free_nxt     = 1'b0;
          do_purge_nxt = full_acc;
          state_nxt    = (in_op == kcmp_pkg::OP_NOP) ? kcmp_pkg::ST_FINISH
                                                     : kcmp_pkg::ST_SWEEP;
        end
      end
      kcmp_pkg::ST_SWEEP: begin
        pend_nxt     = (iss_r < (AW+1)'(ENTRIES));
        pend_idx_nxt = iss_r[AW-1:0];
        if (pend_nxt) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (pend_r) begin
          if (op_r == kcmp_pkg::OP_INSERT) begin
            if (old_entry) begin
              v_we       = 1'b1;
              purged_nxt = purged_r + 1'b1;
            end
            if (slot_free && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = pend_idx_r;
            end
          end else if (v_rdata && p_rdata.key == key_r && (!found_r || age < best_age_r)) begin
            found_nxt    = 1'b1;
            best_idx_nxt = pend_idx_r;
            best_age_nxt = age;
            best_val_nxt = p_rdata.value;
          end
        end
        if (!pend_nxt && !pend_r) begin
          state_nxt = kcmp_pkg::ST_FINISH;
        end
      end
      kcmp_pkg::ST_FINISH: begin
        if (!(out_valid && out_stall)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = kcmp_pkg::ST_IDLE;
          case (op_r)
            kcmp_pkg::OP_FETCH: begin
              hit_nxt    = found_r;
              dout_nxt   = found_r ? best_val_r : '0;
              status_nxt = found_r ? kcmp_pkg::STS_DONE : kcmp_pkg::STS_MISS;
            end
            kcmp_pkg::OP_REMOVE: begin
              hit_nxt    = found_r;
              status_nxt = found_r ? kcmp_pkg::STS_DONE : kcmp_pkg::STS_MISS;
              if (found_r) begin
                v_we      = 1'b1;
                v_waddr   = best_idx_r;
                count_nxt = count_r - 1'b1;
              end
            end
            kcmp_pkg::OP_INSERT: begin
              count_nxt = CW'(cnt_left);
              if (!full_left && free_r) begin
                v_we       = 1'b1;
                v_waddr    = free_idx_r;
                v_wdata    = 1'b1;
                p_we       = 1'b1;
                serial_nxt = serial_r + 32'd1;
                count_nxt  = CW'(cnt_inc);
                dout_nxt   = din_r;
                if (cnt_inc == XW'(fmark_r)) begin
                  mark_nxt = now_r;
                end
              end else begin
                status_nxt = kcmp_pkg::STS_REFUSED;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = kcmp_pkg::ST_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= XW'(ENTRIES)) else $error("entry count above capacity");

  a_purge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kcmp_pkg::ST_FINISH |-> purged_r <= count_r)
    else $error("purged more than held");

  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == kcmp_pkg::STS_DONE)
    else $error("hit with failing status");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kcmp_pkg::ST_CLEAR |-> in_stall && !out_valid)
    else $error("transfer during clearing pass");

endmodule
`default_nettype wire

// ----- tb/tb_keyed_cache_with_mark_purge_top.sv -----
// ----------------------------------------------------------------------------
// tb_keyed_cache_with_mark_purge_top
// self-checking bench for the keyed cache with mark purge: directed and
// random fetch, insert and remove transfers are mirrored in a behavioral
// store that predicts every result; results are compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_keyed_cache_with_mark_purge_top;

  localparam int SLOTS = 256;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_data_in = '0;
  logic [31:0] in_now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [31:0] out_data_out;
  logic [1:0] out_status;
  logic [8:0] out_entry_count;
  logic [8:0] out_purged_count;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  keyed_cache_with_mark_purge_top uut (.*);

  typedef struct packed {
    logic        hit;
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [8:0]  entry_count;
    logic [8:0]  purged_count;
  } answer_t;

  // mirror of the store
  logic        slot_used [SLOTS];
  logic [31:0] slot_key [SLOTS];
  logic [31:0] slot_val [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [31:0] slot_seq [SLOTS];
  logic [31:0] seq_ctr;
  int unsigned held;
  logic [31:0] mark_stamp;
  int unsigned max_reg;
  int unsigned fmark_reg;

  answer_t pending_answers[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit hold_out = 1'b0;
  logic [31:0] clock_now = 32'd1000;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int find_latest(logic [31:0] k);
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == k) begin
        age = seq_ctr - slot_seq[i];
        if (best < 0 || age < best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic bit store_is_full();
    return held >= max_reg || held >= SLOTS;
  endfunction

  function automatic answer_t apply_op(kcmp_pkg::op_t op, logic [31:0] k, logic [31:0] d,
                                       logic [31:0] t);
    answer_t a;
    int s;
    int unsigned purged;
    a = '0;
    purged = 0;
    case (op)
      kcmp_pkg::OP_FETCH, kcmp_pkg::OP_REMOVE: begin
        s = find_latest(k);
        if (s >= 0) begin
          a.hit = 1'b1;
          if (op == kcmp_pkg::OP_FETCH) begin
            a.data_out = slot_val[s];
          end else begin
            slot_used[s] = 1'b0;
            held--;
          end
        end else begin
          a.status = kcmp_pkg::STS_MISS;
        end
      end
      kcmp_pkg::OP_INSERT: begin
        if (store_is_full()) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_stamp[i] < mark_stamp) begin
              slot_used[i] = 1'b0;
              purged++;
            end
          end
          held -= purged;
        end
        if (store_is_full()) begin
          a.status = kcmp_pkg::STS_REFUSED;
        end else begin
          s = 0;
          while (slot_used[s]) s++;
          slot_used[s] = 1'b1;
          slot_key[s] = k;
          slot_val[s] = d;
          slot_stamp[s] = t;
          seq_ctr++;
          slot_seq[s] = seq_ctr;
          held++;
          if (held == fmark_reg) mark_stamp = t;
          a.data_out = d;
        end
      end
      default: ;
    endcase
    a.entry_count = held[8:0];
    a.purged_count = purged[8:0];
    return a;
  endfunction

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // valid stays up after a transfer until the next item, a gap or a drain
  task automatic send_item(kcmp_pkg::op_t op, logic [31:0] k, logic [31:0] d,
                           logic [31:0] t);
    sender_gap();
    pending_answers.push_back(apply_op(op, k, d, t));
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= k;
    in_data_in <= d;
    in_now <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // receiver stall
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) out_stall <= 1'b1;
      else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  // result check
  always @(posedge clk) begin
    answer_t exp_a;
    answer_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hit, out_data_out, out_status, out_entry_count, out_purged_count};
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected transfer %h", $time, got);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (got.hit !== exp_a.hit) begin
          $display("%0t hit exp %h got %h", $time, exp_a.hit, got.hit); errors++;
        end
        if (got.data_out !== exp_a.data_out) begin
          $display("%0t data_out exp %h got %h", $time, exp_a.data_out, got.data_out);
          errors++;
        end
        if (got.status !== exp_a.status) begin
          $display("%0t status exp %h got %h", $time, exp_a.status, got.status); errors++;
        end
        if (got.entry_count !== exp_a.entry_count) begin
          $display("%0t entry_count exp %0d got %0d", $time, exp_a.entry_count,
                   got.entry_count);
          errors++;
        end
        if (got.purged_count !== exp_a.purged_count) begin
          $display("%0t purged_count exp %0d got %0d", $time, exp_a.purged_count,
                   got.purged_count);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SLOTS + 10) @(posedge clk);
  endtask

  task automatic write_reg(kcmp_pkg::cfg_idx_t idx, int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == kcmp_pkg::CFG_MAX) max_reg = v;
    else fmark_reg = v;
  endtask

  function automatic logic [31:0] tick();
    clock_now = clock_now + $urandom_range(1, 20);
    return clock_now;
  endfunction

  task automatic test_directed();
    send_item(kcmp_pkg::OP_FETCH, 32'h0, 32'h0, 32'h0);
    send_item(kcmp_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(kcmp_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(kcmp_pkg::OP_INSERT, 32'h0, 32'h0, 32'h0);
    send_item(kcmp_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 32'h10);
    send_item(kcmp_pkg::OP_FETCH, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h11);
    send_item(kcmp_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h12);
    send_item(kcmp_pkg::OP_FETCH, 32'hFFFF_FFFF, 32'h0, 32'h13);
    send_item(kcmp_pkg::OP_FETCH, 32'h0, 32'h0, 32'h14);
    send_item(kcmp_pkg::OP_NOP, 32'h5555_5555, 32'hAAAA_AAAA, 32'h15);
    send_item(kcmp_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h16);
    send_item(kcmp_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h17);
    send_item(kcmp_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h18);
  endtask

  task automatic test_zero_max();
    write_reg(kcmp_pkg::CFG_MAX, 0);
    send_item(kcmp_pkg::OP_INSERT, 32'h1, 32'h2, 32'h3);
    send_item(kcmp_pkg::OP_INSERT, 32'h1, 32'h2, 32'h4);
    write_reg(kcmp_pkg::CFG_MAX, 256);
  endtask

  // random mix of operations under the given max and mark, filling the store so that overflow purges by mark
  task automatic test_purge(int unsigned mx, int unsigned fm, int n);
    write_reg(kcmp_pkg::CFG_MAX, mx);
    write_reg(kcmp_pkg::CFG_FMARK, fm);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send_item(kcmp_pkg::OP_FETCH, $urandom_range(0, 7), $urandom, tick());
        2: send_item(kcmp_pkg::OP_REMOVE, $urandom_range(0, 7), $urandom, tick());
        3: send_item(kcmp_pkg::OP_NOP, $urandom, $urandom, tick());
        default: send_item(kcmp_pkg::OP_INSERT, $urandom_range(0, 7), $urandom, tick());
      endcase
    end
    drain();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = slot_used[i];
  endtask

  task automatic test_full_store();
    write_reg(kcmp_pkg::CFG_MAX, 511);
    write_reg(kcmp_pkg::CFG_FMARK, 256);
    for (int i = 0; i < SLOTS + 2; i++)
      send_item(kcmp_pkg::OP_INSERT, i % 5, $urandom, tick());
    send_item(kcmp_pkg::OP_FETCH, 32'd3, 32'd0, tick());
    send_item(kcmp_pkg::OP_REMOVE, 32'd3, 32'd0, tick());
    send_item(kcmp_pkg::OP_INSERT, 32'd9, 32'hDEAD_BEEF, tick());
    send_item(kcmp_pkg::OP_INSERT, 32'd9, 32'hBEEF, tick());
  endtask

  task automatic test_backpressure();
    write_reg(kcmp_pkg::CFG_MAX, 256);
    write_reg(kcmp_pkg::CFG_FMARK, 192);
    hold_out = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 10; i++)
        send_item(kcmp_pkg::op_t'($urandom_range(0, 2)), $urandom_range(0, 3), $urandom,
                  tick());
    join
  endtask

  task automatic test_random(int n);
    write_reg(kcmp_pkg::CFG_MAX, $urandom_range(1, 12));
    write_reg(kcmp_pkg::CFG_FMARK, $urandom_range(1, 10));
    for (int i = 0; i < n; i++) begin
      if (i == n - 40) quiet = 1'b1;
      send_item(kcmp_pkg::op_t'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom,
                $urandom, $urandom_range(0, 15) == 0 ? $urandom : tick());
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_stamp[i] = '0;
      slot_seq[i] = '0;
    end
    seq_ctr = '0;
    held = 0;
    mark_stamp = '0;
    max_reg = kcmp_pkg::MAX_RST;
    fmark_reg = kcmp_pkg::FMARK_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_max();
    test_purge(6, 4, 40);
    test_purge(1, 1, 15);
    test_purge(10, 0, 25);
    test_backpressure();
    test_full_store();
    test_random(60);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
